[src/bpdc_pkg.sv]
// Package for the button press duration classifier.
// Holds field widths, opcodes, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bpdc_pkg;

   localparam int TIME_W     = 32;
   localparam int INDEX_W    = 3;
   localparam int LEVEL_BITS = 8;
   localparam int COUNT_W    = 4;

   localparam logic [TIME_W-1:0]  DEBOUNCE_MS          = 32'd50;
   localparam logic [TIME_W-1:0]  LONG_PRESS_RESET     = 32'd1000;
   localparam logic [COUNT_W-1:0] BUTTON_COUNT_RESET   = 4'd8;

   localparam logic OPC_PRESS = 1'b0;
   localparam logic OPC_TICK  = 1'b1;

   localparam logic [0:0] REG_LONG_PRESS   = 1'b0;
   localparam logic [0:0] REG_BUTTON_COUNT = 1'b1;

   typedef struct packed {
      logic ev;
      logic is_long;
   } lane_status_type;

endpackage

[src/bpdc_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on bpdc_pkg for the field widths.
`timescale 1ns / 1ps

interface bpdc_req_if;
   import bpdc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [INDEX_W-1:0]    button_index;
   logic [TIME_W-1:0]     now_ms;
   logic [LEVEL_BITS-1:0] button_levels;

   modport source (output valid, output opcode, output button_index, output now_ms,
                   output button_levels, input ready);
   modport sink (input valid, input opcode, input button_index, input now_ms,
                 input button_levels, output ready);
endinterface

interface bpdc_rsp_if;
   import bpdc_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] event_button;
   logic               is_long;
   logic               last_event;

   modport source (output valid, output event_button, output is_long, output last_event,
                   input ready);
   modport sink (input valid, input event_button, input is_long, input last_event,
                 output ready);
endinterface

[src/bpdc_lane.sv]
// One button lane: press time, held flag and the classified release of a tick.
// Depends on bpdc_pkg.
`timescale 1ns / 1ps

module bpdc_lane #(
   parameter int LANE_ID = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           press_en,
   input  logic                           tick_en,
   input  logic [bpdc_pkg::INDEX_W-1:0]   button_index,
   input  logic [bpdc_pkg::TIME_W-1:0]    now_ms,
   input  logic                           level,
   input  logic [bpdc_pkg::TIME_W-1:0]    long_press_ms,
   input  logic [bpdc_pkg::COUNT_W-1:0]   button_count,
   input  logic                           clear,
   output bpdc_pkg::lane_status_type      status
);
   import bpdc_pkg::*;

   localparam logic [COUNT_W-1:0] LANE_NUM = COUNT_W'(LANE_ID);
   localparam logic [INDEX_W-1:0] LANE_IDX = INDEX_W'(LANE_ID);

   logic [TIME_W-1:0] start_ff, start_in;
   logic              held_ff, held_in;
   logic              ev_ff, ev_in;
   logic              long_ff, long_in;
   logic              active, press_hit, release_hit;
   logic [TIME_W-1:0] held_time;

   always_comb begin
      active      = LANE_NUM < button_count;
      press_hit   = press_en && (button_index == LANE_IDX) && active && !held_ff;
      release_hit = tick_en && active && held_ff && level;
      held_time   = now_ms - start_ff;

      start_in = start_ff;
      held_in  = held_ff;
      ev_in    = ev_ff;
      long_in  = long_ff;
      if (press_hit) begin
         start_in = now_ms;
         held_in  = 1'b1;
      end
      if (clear) begin
         ev_in = 1'b0;
      end
      if (release_hit) begin
         held_in = 1'b0;
         ev_in   = held_time >= DEBOUNCE_MS;
         long_in = held_time >= long_press_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         ev_ff   <= 1'b0;
      end else begin
         held_ff <= held_in;
         ev_ff   <= ev_in;
      end
      start_ff <= start_in;
      long_ff  <= long_in;
   end

   assign status.ev      = ev_ff;
   assign status.is_long = long_ff;

endmodule

[src/bpdc_merge.sv]
// Merging stage: emits the pending lane events in ascending button order.
// Depends on bpdc_pkg and bpdc_rsp_if.
`timescale 1ns / 1ps

module bpdc_merge #(
   parameter int NUM_LANES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bpdc_pkg::lane_status_type lane_status [NUM_LANES],
   output logic [NUM_LANES-1:0]      clear,
   bpdc_rsp_if.source                rsp_ch
);
   import bpdc_pkg::*;

   logic [NUM_LANES-1:0] ev_vec, long_vec, first_oh;
   logic [INDEX_W-1:0]   first_idx;
   logic                 found, load, last;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_button_ff, rsp_button_in;
   logic               rsp_long_ff, rsp_long_in;
   logic               rsp_last_ff, rsp_last_in;

   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      first_oh  = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         ev_vec[i]   = lane_status[i].ev;
         long_vec[i] = lane_status[i].is_long;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         if (ev_vec[i] && !found) begin
            found       = 1'b1;
            first_idx   = INDEX_W'(i);
            first_oh[i] = 1'b1;
         end
      end
      load = found && (!rsp_valid_ff || rsp_ch.ready);
      last = (ev_vec & ~first_oh) == '0;
      clear = load ? first_oh : '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_button_in = rsp_button_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_button_in = first_idx;
         rsp_long_in   = |(long_vec & first_oh);
         rsp_last_in   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_button_ff <= rsp_button_in;
      rsp_long_ff   <= rsp_long_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.event_button = rsp_button_ff;
   assign rsp_ch.is_long      = rsp_long_ff;
   assign rsp_ch.last_event   = rsp_last_ff;

   a_clear_pending: assert property (@(posedge clock) disable iff (reset)
      (clear & ~ev_vec) == '0)
      else $error("merge cleared a lane with no pending event");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      load && last |=> ev_vec == '0)
      else $error("events remain after the last event was issued");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> clear == '0)
      else $error("stalled response was overwritten");

endmodule

[src/button_press_duration_classifier_top.sv]
// Top level of the button press duration classifier: CSR port, lanes and merge.
// Depends on bpdc_pkg, bpdc_if, bpdc_lane and bpdc_merge.
`timescale 1ns / 1ps

//  Channel   Direction  Transaction
//  req_ch    in         press edge or tick scan (opcode, index, time, levels)
//  rsp_ch    out        one release event (button, short or long, last of tick)
//  csr_*     in/out     APB-style register write and read
//
// A press is registered in its lane. All lanes scan a tick together; each
// event then leaves through the merge register at one per cycle unless the
// response stalls; the next request waits until the merge has taken them all.
// Reset is synchronous and clears all held flags, pending events and CSRs.
// A stalled response holds its payload; a final event that waits does not
// block the next request.

module button_press_duration_classifier_top #(
   parameter int MAX_BUTTONS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   bpdc_req_if.sink                    req_ch,
   bpdc_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import bpdc_pkg::*;

   localparam int NUM_LANES = (MAX_BUTTONS < LEVEL_BITS) ? MAX_BUTTONS : LEVEL_BITS;

   logic [TIME_W-1:0]  long_press_ff, long_press_in;
   logic [COUNT_W-1:0] button_count_ff, button_count_in;
   logic               csr_write;
   logic [0:0]         reg_index;

   lane_status_type      lane_status [NUM_LANES];
   logic [NUM_LANES-1:0] clear;
   logic [NUM_LANES-1:0] ev_vec;
   logic                 accept, press_en, tick_en;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2:2];

   always_comb begin
      long_press_in   = long_press_ff;
      button_count_in = button_count_ff;
      csr_prdata      = '0;
      case (reg_index)
         REG_LONG_PRESS: begin
            csr_prdata = long_press_ff;
            if (csr_write) long_press_in = csr_pwdata;
         end
         REG_BUTTON_COUNT: begin
            csr_prdata = {28'b0, button_count_ff};
            if (csr_write) button_count_in = csr_pwdata[COUNT_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RESET;
         button_count_ff <= BUTTON_COUNT_RESET;
      end else begin
         long_press_ff   <= long_press_in;
         button_count_ff <= button_count_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         ev_vec[i] = lane_status[i].ev;
      end
   end

   assign req_ch.ready = ev_vec == '0;
   assign accept       = req_ch.valid && req_ch.ready;
   assign press_en     = accept && (req_ch.opcode == OPC_PRESS);
   assign tick_en      = accept && (req_ch.opcode == OPC_TICK);

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      bpdc_lane #(.LANE_ID(g)) u_lane (
         .clock         (clock),
         .reset         (reset),
         .press_en      (press_en),
         .tick_en       (tick_en),
         .button_index  (req_ch.button_index),
         .now_ms        (req_ch.now_ms),
         .level         (req_ch.button_levels[g]),
         .long_press_ms (long_press_ff),
         .button_count  (button_count_ff),
         .clear         (clear[g]),
         .status        (lane_status[g])
      );
   end

   bpdc_merge #(.NUM_LANES(NUM_LANES)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_status (lane_status),
      .clear       (clear),
      .rsp_ch      (rsp_ch)
   );

endmodule
